// ===== rtl/drt_pkg.sv =====
// Package for the device registry table: command codes, defaults, sequencer states.
// No dependencies.
package drt_pkg;

  localparam int MaxEntriesDef = 8;
  localparam int KeyBitsDef    = 48;
  localparam int InKeyBits     = 48;
  localparam int OutKeyBits    = 48;

  typedef enum logic [3:0] {
    CMD_CONNECT   = 4'd0,
    CMD_REMOVE    = 4'd1,
    CMD_SELECT    = 4'd2,
    CMD_CLR_SEL   = 4'd3,
    CMD_CLR_ALL   = 4'd4,
    CMD_GET       = 4'd5,
    CMD_PREFERRED = 4'd6,
    CMD_ID_KEY    = 4'd7,
    CMD_ID_TYPE   = 4'd8
  } cmd_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_SHIFT = 7'b0000100,
    ST_NUM   = 7'b0001000,
    ST_WRITE = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

endpackage

// ===== rtl/device_registry_table.sv =====
// Device registry table top level: storage, command sequencer, result register.
// Depends on drt_pkg.
//
//  channel | ports                                          | direction
//  in      | in_valid, in_stall, in_cmd .. in_entry_index_in | into block
//  out     | out_valid, out_stall, out_ok .. out_count_now    | out of block
//
// For select, clear, get, preferred and unknown codes the command passes through
// ST_DONE and ST_READ before the result is registered. Lookups walk one entry a
// cycle through a single compare unit, and compaction moves one entry a cycle. The
// worst case is a connect to a full table: scan, evict, then a free-number search
// that restarts on each clash.
// in_stall is high whenever a command is in progress or a result waits.
// Reset (rst_n low, synchronous) empties the table and clears last/selected.
// A result waits in the output register while out_stall is high.
module device_registry_table #(
  parameter int MAX_ENTRIES = drt_pkg::MaxEntriesDef,
  parameter int KEY_BITS    = drt_pkg::KeyBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_cmd,
  input  logic [47:0] in_addr_key,
  input  logic [7:0]  in_addr_type,
  input  logic [7:0]  in_camera_type,
  input  logic [3:0]  in_entry_index_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [2:0]  out_entry_index,
  output logic [3:0]  out_camera_number,
  output logic [47:0] out_found_addr_key,
  output logic [7:0]  out_found_addr_type,
  output logic [7:0]  out_found_camera_type,
  output logic [3:0]  out_count_now
);
  import drt_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int NW = $clog2(MAX_ENTRIES + 1);

  // entry storage
  logic [KEY_BITS-1:0] key_mem  [MAX_ENTRIES];
  logic [7:0]          atype_mem[MAX_ENTRIES];
  logic [7:0]          ctype_mem[MAX_ENTRIES];
  logic [NW-1:0]       num_mem  [MAX_ENTRIES];

  state_t state_r, state_nxt;
  cmd_t   cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [7:0]  atype_r, ctype_r;
  logic [3:0]  ix_r;
  logic [CW-1:0] count_r;
  logic          last_v_r, sel_v_r;
  logic [IW-1:0] last_r, sel_r;
  logic [CW-1:0] ptr_r;        // walk pointer
  logic [CW-1:0] tgt_r;        // entry to write or report
  logic [CW-1:0] shend_r;      // compaction end (exclusive)
  logic [NW-1:0] cand_r;       // candidate number in free search
  logic          found_r;
  logic          okres_r;      // ok when reporting
  logic          rep_r;        // report entry fields

  logic          out_valid_r, out_ok_r;
  logic [2:0]    out_idx_r;
  logic [3:0]    out_num_r, out_cnt_r;
  logic [47:0]   out_key_r;
  logic [7:0]    out_at_r, out_ct_r;

  logic [IW-1:0] p_ix;
  assign p_ix = ptr_r[IW-1:0];
  logic [IW-1:0] t_ix;
  assign t_ix = tgt_r[IW-1:0];
  logic [IW-1:0] p1_ix;
  assign p1_ix = IW'(ptr_r + 1'b1);

  logic in_acc;
  assign in_stall = (state_r != ST_IDLE) || out_valid_r;
  assign in_acc   = in_valid && !in_stall;

  // shared compare unit: one entry per cycle
  logic key_hit, type_hit, num_hit, ptr_in;
  assign ptr_in   = ptr_r < count_r;
  assign key_hit  = ptr_in && (key_mem[p_ix] == key_r);
  assign type_hit = ptr_in && (ctype_mem[p_ix] == ctype_r);
  assign num_hit  = ptr_in && (num_mem[p_ix] == cand_r);

  logic ix_ok;
  assign ix_ok = {1'b0, ix_r} < 5'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      last_v_r    <= 1'b0;
      sel_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r   <= cmd_t'(in_cmd);
            key_r   <= KEY_BITS'(in_addr_key);
            atype_r <= in_addr_type;
            ctype_r <= in_camera_type;
            ix_r    <= in_entry_index_in;
            found_r <= 1'b0;
            rep_r   <= 1'b0;
            okres_r <= 1'b0;
            cand_r  <= NW'(1);
            // identity by type: last entry first, then walk down
            ptr_r   <= (in_cmd == CMD_ID_TYPE) ? count_r - 1'b1 : '0;
          end
        end
        ST_SCAN: begin
          case (cmd_r)
            CMD_CONNECT, CMD_ID_KEY: begin
              if (key_hit) begin
                found_r <= 1'b1;
                tgt_r   <= ptr_r;
              end else if (ptr_in) ptr_r <= ptr_r + 1'b1;
            end
            CMD_ID_TYPE: begin
              if (type_hit) begin
                found_r <= 1'b1;
                tgt_r   <= ptr_r;
              end else ptr_r <= ptr_r - 1'b1;
            end
            default: ;
          endcase
        end
        ST_SHIFT: begin
          // advance one entry down per cycle
          if (ptr_r + 1'b1 < shend_r) begin
            key_mem[p_ix]   <= key_mem[p1_ix];
            atype_mem[p_ix] <= atype_mem[p1_ix];
            ctype_mem[p_ix] <= ctype_mem[p1_ix];
            num_mem[p_ix]   <= num_mem[p1_ix];
            ptr_r <= ptr_r + 1'b1;
          end else begin
            count_r <= count_r - 1'b1;
            ptr_r   <= '0;
          end
        end
        ST_NUM: begin
          // lowest free number: restart the walk on each clash
          if (num_hit) begin
            cand_r <= cand_r + 1'b1;
            ptr_r  <= '0;
          end else if (ptr_in) ptr_r <= ptr_r + 1'b1;
        end
        default: ;
      endcase

      // per-command actions on leaving a stage
      if (state_r == ST_SHIFT && !(ptr_r + 1'b1 < shend_r)) begin
        if (cmd_r == CMD_CONNECT) begin
          if (last_v_r && CW'(last_r) > shend_r - shend_r + (last_v_r && last_r == '0 ? CW'(1) : CW'(0)))
            last_r <= last_r - 1'b1;
        end else begin
          if (last_v_r) begin
            if (CW'(last_r) == tgt_r) last_v_r <= 1'b0;
            else if (CW'(last_r) > tgt_r) last_r <= last_r - 1'b1;
          end
          if (sel_v_r) begin
            if (CW'(sel_r) == tgt_r) sel_v_r <= 1'b0;
            else if (CW'(sel_r) > tgt_r) sel_r <= sel_r - 1'b1;
          end
          rep_r   <= 1'b0;
          okres_r <= 1'b1;
        end
      end

      if (state_r == ST_NUM && !num_hit && !ptr_in) begin
        num_mem[t_ix] <= (cand_r > NW'(MAX_ENTRIES)) ? NW'(1) : cand_r;
        count_r <= count_r + 1'b1;
      end

      if (state_r == ST_WRITE) begin
        key_mem[t_ix]   <= key_r;
        atype_mem[t_ix] <= atype_r;
        ctype_mem[t_ix] <= ctype_r;
        last_v_r <= 1'b1;
        last_r   <= t_ix;
        sel_v_r  <= 1'b0;
      end

      if (state_r == ST_READ) begin
        out_valid_r <= 1'b1;
        out_cnt_r   <= 4'(count_r);
        if (rep_r) begin
          out_ok_r  <= okres_r;
          out_idx_r <= 3'(tgt_r);
          out_num_r <= 4'(num_mem[t_ix]);
          out_key_r <= 48'(key_mem[t_ix]);
          out_at_r  <= atype_mem[t_ix];
          out_ct_r  <= ctype_mem[t_ix];
        end else begin
          out_ok_r  <= okres_r;
          out_idx_r <= (cmd_r == CMD_SELECT && okres_r) ? 3'(ix_r) : 3'd0;
          out_num_r <= '0;
          out_key_r <= '0;
          out_at_r  <= '0;
          out_ct_r  <= '0;
        end
      end

      // set-up transitions out of ST_DONE (command dispatch)
      if (state_r == ST_DONE) begin
        case (cmd_r)
          CMD_CONNECT: begin
            if (found_r) begin
              rep_r <= 1'b1; okres_r <= 1'b1;
            end else begin
              rep_r <= 1'b1; okres_r <= 1'b1;
              tgt_r <= count_r;
            end
          end
          CMD_REMOVE: begin
            if (ix_ok) begin
              tgt_r   <= CW'(ix_r);
              ptr_r   <= CW'(ix_r);
              shend_r <= count_r;
            end
          end
          CMD_SELECT: begin
            if (ix_ok) begin
              sel_v_r <= 1'b1; sel_r <= IW'(ix_r); okres_r <= 1'b1;
            end
          end
          CMD_CLR_SEL: begin
            sel_v_r <= 1'b0; okres_r <= 1'b1;
          end
          CMD_CLR_ALL: begin
            count_r <= '0; last_v_r <= 1'b0; sel_v_r <= 1'b0; okres_r <= 1'b1;
          end
          CMD_GET: begin
            if (ix_ok) begin
              rep_r <= 1'b1; okres_r <= 1'b1; tgt_r <= CW'(ix_r);
            end
          end
          CMD_PREFERRED: begin
            if (sel_v_r ? (CW'(sel_r) < count_r && ctype_mem[sel_r] == ctype_r)
                        : (last_v_r && CW'(last_r) < count_r
                           && ctype_mem[last_r] == ctype_r)) begin
              rep_r <= 1'b1; okres_r <= 1'b1;
              tgt_r <= sel_v_r ? CW'(sel_r) : CW'(last_r);
            end
          end
          CMD_ID_KEY: ;
          CMD_ID_TYPE: begin
            if (last_v_r && CW'(last_r) < count_r && ctype_mem[last_r] == ctype_r) begin
              found_r <= 1'b1;
              tgt_r   <= CW'(last_r);
              rep_r   <= 1'b1;
              okres_r <= num_mem[last_r] != '0;
            end
          end
          default: ;
        endcase
      end

      // results of scans
      if (state_r == ST_SCAN && (cmd_r == CMD_ID_KEY || cmd_r == CMD_ID_TYPE)) begin
        if (cmd_r == CMD_ID_KEY ? key_hit : type_hit) begin
          rep_r   <= 1'b1;
          okres_r <= num_mem[p_ix] != '0;
        end
      end
      if (state_r == ST_SCAN && cmd_r == CMD_CONNECT && !key_hit && !ptr_in) begin
        if (count_r >= CW'(MAX_ENTRIES)) begin
          // full: evict the oldest that is not the last connected
          ptr_r   <= (last_v_r && last_r == '0) ? CW'(1) : CW'(0);
          shend_r <= count_r;
        end else begin
          tgt_r <= count_r;
          ptr_r <= '0;
        end
        rep_r <= 1'b1; okres_r <= 1'b1;
      end
      if (state_r == ST_SCAN && cmd_r == CMD_CONNECT && key_hit) begin
        rep_r <= 1'b1; okres_r <= 1'b1;
      end
      if (state_r == ST_SHIFT && cmd_r == CMD_CONNECT
          && !(ptr_r + 1'b1 < shend_r)) begin
        tgt_r <= count_r - 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_DONE;
      ST_DONE: begin
        case (cmd_r)
          CMD_CONNECT, CMD_ID_KEY: state_nxt = ST_SCAN;
          CMD_REMOVE: state_nxt = ix_ok ? ST_SHIFT : ST_READ;
          CMD_ID_TYPE: state_nxt =
            (last_v_r && CW'(last_r) < count_r && ctype_mem[last_r] == ctype_r)
            ? ST_READ : ST_SCAN;
          default: state_nxt = ST_READ;
        endcase
      end
      ST_SCAN: begin
        case (cmd_r)
          CMD_CONNECT: begin
            if (key_hit) state_nxt = ST_WRITE;
            else if (!ptr_in)
              state_nxt = (count_r >= CW'(MAX_ENTRIES)) ? ST_SHIFT : ST_NUM;
          end
          CMD_ID_KEY: if (key_hit || !ptr_in) state_nxt = ST_READ;
          default: if (type_hit || !ptr_in) state_nxt = ST_READ;
        endcase
      end
      ST_SHIFT: if (!(ptr_r + 1'b1 < shend_r))
        state_nxt = (cmd_r == CMD_CONNECT) ? ST_NUM : ST_READ;
      ST_NUM: if (!num_hit && !ptr_in) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_ok                = out_ok_r;
  assign out_entry_index       = out_idx_r;
  assign out_camera_number     = out_num_r;
  assign out_found_addr_key    = out_key_r;
  assign out_found_addr_type   = out_at_r;
  assign out_found_camera_type = out_ct_r;
  assign out_count_now         = out_cnt_r;

  // count stays within capacity, input stalls while busy, each read gives a result
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES)) else $error("count beyond capacity");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall) else $error("input open while busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_READ |=> out_valid) else $error("result lost");

endmodule

// ===== verif/drt_checker.sv =====
// Checker for the device registry table: watches both channels, predicts each result
// from its own copy of the table and compares field by field. Depends on drt_pkg.
`timescale 1ns / 100ps
module drt_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  in_cmd,
  input  logic [47:0] in_addr_key,
  input  logic [7:0]  in_addr_type,
  input  logic [7:0]  in_camera_type,
  input  logic [3:0]  in_entry_index_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_ok,
  input  logic [2:0]  out_entry_index,
  input  logic [3:0]  out_camera_number,
  input  logic [47:0] out_found_addr_key,
  input  logic [7:0]  out_found_addr_type,
  input  logic [7:0]  out_found_camera_type,
  input  logic [3:0]  out_count_now,
  output int          fail_count,
  output int          pending_count
);
  import drt_pkg::*;

  localparam int Depth = MaxEntriesDef;

  typedef struct packed {
    logic        ok;
    logic [2:0]  idx;
    logic [3:0]  number;
    logic [47:0] key;
    logic [7:0]  atype;
    logic [7:0]  ctype;
    logic [3:0]  count;
  } reply_t;

  logic [47:0] tbl_key   [Depth];
  logic [7:0]  tbl_atype [Depth];
  logic [7:0]  tbl_ctype [Depth];
  logic [3:0]  tbl_num   [Depth];
  int          n_entries;
  bit          last_ok, sel_ok;
  int          last_at, sel_at;
  reply_t      expected_replies[$];

  assign pending_count = expected_replies.size();

  task automatic report_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void fill(inout reply_t r, input int i);
    r.idx = i[2:0]; r.number = tbl_num[i]; r.key = tbl_key[i];
    r.atype = tbl_atype[i]; r.ctype = tbl_ctype[i];
  endfunction

  function automatic void wipe();
    for (int i = 0; i < Depth; i++) begin
      tbl_key[i] = '0; tbl_atype[i] = '0; tbl_ctype[i] = '0; tbl_num[i] = '0;
    end
    n_entries = 0; last_ok = 0; last_at = 0; sel_ok = 0; sel_at = 0;
  endfunction

  // Move entries above 'from' one place down.
  function automatic void close_gap(input int from);
    for (int i = from; i + 1 < n_entries; i++) begin
      tbl_key[i] = tbl_key[i+1]; tbl_atype[i] = tbl_atype[i+1];
      tbl_ctype[i] = tbl_ctype[i+1]; tbl_num[i] = tbl_num[i+1];
    end
  endfunction

  function automatic reply_t apply_command(input logic [3:0] c, input logic [47:0] k,
                                           input logic [7:0] at, input logic [7:0] ct,
                                           input logic [3:0] ix);
    reply_t r;
    int     idx, ev;
    bit     hit;
    bit     used[Depth+1];
    r = '0;
    case (c)
      CMD_CONNECT: begin
        hit = 0; idx = 0;
        for (int i = 0; i < n_entries; i++)
          if (!hit && tbl_key[i] == k) begin hit = 1; idx = i; end
        if (!hit) begin
          if (n_entries >= Depth) begin
            ev = (last_ok && last_at == 0) ? 1 : 0;
            close_gap(ev);
            n_entries--;
            if (last_ok && last_at > ev) last_at--;
          end
          idx = n_entries;
          for (int n = 0; n <= Depth; n++) used[n] = 0;
          for (int i = 0; i < idx; i++)
            if (tbl_num[i] > 0 && tbl_num[i] <= Depth) used[tbl_num[i]] = 1;
          tbl_num[idx] = 1;
          for (int n = Depth; n >= 1; n--) if (!used[n]) tbl_num[idx] = n[3:0];
          n_entries++;
        end
        tbl_key[idx] = k; tbl_atype[idx] = at; tbl_ctype[idx] = ct;
        last_ok = 1; last_at = idx; sel_ok = 0;
        r.ok = 1; fill(r, idx);
      end
      CMD_REMOVE: if (ix < n_entries) begin
        close_gap(ix);
        n_entries--;
        tbl_key[n_entries] = '0; tbl_atype[n_entries] = '0;
        tbl_ctype[n_entries] = '0; tbl_num[n_entries] = '0;
        if (last_ok) begin
          if (last_at == ix) last_ok = 0; else if (last_at > ix) last_at--;
        end
        if (sel_ok) begin
          if (sel_at == ix) sel_ok = 0; else if (sel_at > ix) sel_at--;
        end
        r.ok = 1;
      end
      CMD_SELECT: if (ix < n_entries) begin
        sel_ok = 1; sel_at = ix; r.ok = 1; r.idx = ix[2:0];
      end
      CMD_CLR_SEL: begin sel_ok = 0; r.ok = 1; end
      CMD_CLR_ALL: begin wipe(); r.ok = 1; end
      CMD_GET: if (ix < n_entries) begin r.ok = 1; fill(r, ix); end
      CMD_PREFERRED: begin
        idx = sel_ok ? sel_at : last_at;
        if ((sel_ok || last_ok) && idx < n_entries && tbl_ctype[idx] == ct) begin
          r.ok = 1; fill(r, idx);
        end
      end
      CMD_ID_KEY: begin
        hit = 0;
        for (int i = 0; i < n_entries; i++)
          if (!hit && tbl_key[i] == k) begin
            hit = 1; r.ok = tbl_num[i] != 0; fill(r, i);
          end
      end
      CMD_ID_TYPE: begin
        if (last_ok && last_at < n_entries && tbl_ctype[last_at] == ct) begin
          r.ok = tbl_num[last_at] != 0; fill(r, last_at);
        end else begin
          hit = 0;
          for (int j = n_entries - 1; j >= 0; j--)
            if (!hit && tbl_ctype[j] == ct) begin
              hit = 1; r.ok = tbl_num[j] != 0; fill(r, j);
            end
        end
      end
      default: ;
    endcase
    r.count = n_entries[3:0];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    wipe();
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      wipe();
      expected_replies.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_replies.push_back(apply_command(in_cmd, in_addr_key, in_addr_type,
                                                 in_camera_type, in_entry_index_in));
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $display("%0t result transfer with nothing expected", $time);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_ok !== want.ok) report_mismatch("ok", out_ok, want.ok);
          if (out_entry_index !== want.idx)
            report_mismatch("entry_index", out_entry_index, want.idx);
          if (out_camera_number !== want.number)
            report_mismatch("camera_number", out_camera_number, want.number);
          if (out_found_addr_key !== want.key)
            report_mismatch("found_addr_key", out_found_addr_key, want.key);
          if (out_found_addr_type !== want.atype)
            report_mismatch("found_addr_type", out_found_addr_type, want.atype);
          if (out_found_camera_type !== want.ctype)
            report_mismatch("found_camera_type", out_found_camera_type, want.ctype);
          if (out_count_now !== want.count)
            report_mismatch("count_now", out_count_now, want.count);
        end
      end
    end
  end
endmodule

// ===== verif/tb_device_registry_table.sv =====
// Testbench top for the device registry table: drives command transfers and result
// stalls, and gives the verdict. Depends on drt_pkg, device_registry_table, drt_checker.
`timescale 1ns / 100ps
module tb_device_registry_table;
  import drt_pkg::*;

  localparam int IdleLimit = 5000;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [3:0]  in_cmd;
  logic [47:0] in_addr_key;
  logic [7:0]  in_addr_type, in_camera_type;
  logic [3:0]  in_entry_index_in;
  logic        out_valid, out_stall, out_ok;
  logic [2:0]  out_entry_index;
  logic [3:0]  out_camera_number, out_count_now;
  logic [47:0] out_found_addr_key;
  logic [7:0]  out_found_addr_type, out_found_camera_type;
  int          fail_count, pending_count;

  // Idling odds in percent, per phase.
  int          send_gap_pct, recv_stall_pct;
  int          quiet_cycles;
  int          commands_sent;

  // Small pool of keys so connects hit stored entries often.
  logic [47:0] key_pool[12];

  device_registry_table dut (.*);
  drt_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: decide the stall for each cycle at the falling edge.
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("watchdog expired after %0d idle cycles", IdleLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one command and hold it until its transfer; valid drops only
  // when a gap comes before the next command.
  task automatic send_command(input cmd_t c, input logic [47:0] k, input logic [7:0] at,
                              input logic [7:0] ct, input logic [3:0] ix);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_cmd <= c; in_addr_key <= k; in_addr_type <= at;
    in_camera_type <= ct; in_entry_index_in <= ix;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    commands_sent++;
  endtask

  task automatic send_raw(input logic [3:0] c, input logic [47:0] k, input logic [7:0] at,
                          input logic [7:0] ct, input logic [3:0] ix);
    send_command(cmd_t'(c), k, at, ct, ix);
  endtask

  // Mostly well-formed traffic: plenty of connects, indices near the fill level,
  // a few types so type lookups find things, occasional clear-all and bad codes.
  task automatic random_command();
    int          pick;
    logic [3:0]  c, ix;
    logic [47:0] k;
    logic [7:0]  ct;
    pick = $urandom_range(99);
    if (pick < 30) c = CMD_CONNECT;
    else if (pick < 40) c = CMD_REMOVE;
    else if (pick < 50) c = CMD_SELECT;
    else if (pick < 54) c = CMD_CLR_SEL;
    else if (pick < 56) c = CMD_CLR_ALL;
    else if (pick < 66) c = CMD_GET;
    else if (pick < 76) c = CMD_PREFERRED;
    else if (pick < 86) c = CMD_ID_KEY;
    else if (pick < 96) c = CMD_ID_TYPE;
    else c = 4'($urandom_range(15, 9));
    k  = ($urandom_range(9) < 8) ? key_pool[$urandom_range(11)]
                                 : 48'({$urandom, $urandom});
    ct = ($urandom_range(3) < 3) ? 8'($urandom_range(3)) : 8'($urandom);
    ix = ($urandom_range(4) < 4) ? 4'($urandom_range(8)) : 4'($urandom);
    send_raw(c, k, 8'($urandom), ct, ix);
  endtask

  initial begin
    in_valid = 0; in_cmd = '0; in_addr_key = '0; in_addr_type = '0;
    in_camera_type = '0; in_entry_index_in = '0; out_stall = 0;
    send_gap_pct = 0; recv_stall_pct = 0; quiet_cycles = 0; commands_sent = 0;
    rst_n = 0;
    for (int i = 0; i < 12; i++) key_pool[i] = 48'({$urandom, $urandom});
    key_pool[0] = '0;
    key_pool[1] = 48'hFFFF_FFFF_FFFF;
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: empty-table queries, then fill past capacity to force eviction,
    // both extremes of every field, index out of range and unknown codes.
    send_command(CMD_GET, '0, '0, '0, 4'd0);
    send_command(CMD_PREFERRED, '0, '0, '0, '0);
    send_command(CMD_ID_TYPE, '0, '0, '0, '0);
    for (int i = 0; i < 9; i++)
      send_command(CMD_CONNECT, key_pool[i], (i % 2) ? 8'hFF : 8'h00,
                   (i % 2) ? 8'hFF : 8'h00, '0);
    send_command(CMD_CONNECT, key_pool[1], 8'h5A, 8'hA5, '0);
    send_command(CMD_SELECT, '0, '0, '0, 4'd7);
    send_command(CMD_PREFERRED, '0, '0, 8'hA5, '0);
    send_command(CMD_REMOVE, '0, '0, '0, 4'd15);
    send_command(CMD_GET, '0, '0, '0, 4'd8);
    send_command(CMD_REMOVE, '0, '0, '0, 4'd7);
    send_command(CMD_ID_KEY, key_pool[1], '0, '0, '0);
    send_command(CMD_ID_TYPE, '0, '0, 8'hFF, '0);
    send_command(CMD_CLR_SEL, '0, '0, '0, '0);
    send_raw(4'd9, 48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF, 4'hF);
    send_raw(4'd15, '0, '0, '0, '0);
    send_command(CMD_CLR_ALL, '0, '0, '0, '0);

    // Random: three idling phases.
    send_gap_pct = 9;  recv_stall_pct = 48;
    repeat (630) random_command();
    send_gap_pct = 48; recv_stall_pct = 9;
    repeat (630) random_command();
    send_gap_pct = 0;  recv_stall_pct = 0;
    repeat (640) random_command();
    in_valid <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (2 * MaxEntriesDef + 10) @(posedge clk);

    $display("Sent %0d commands across three idling phases, with table overflow,",
             commands_sent);
    $display("compaction, selection and lookups by key and type.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
